/* rtl/tlpc_pkg.sv */
package tlpc_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int REG_WIDTH       = 16;
	localparam int TIME_WIDTH      = 32;
	localparam int CFG_IDX_WIDTH   = 3;
	localparam int IN_TDATA_WIDTH  = 8;
	localparam int IN_TUSER_WIDTH  = 2;
	localparam int OUT_TDATA_WIDTH = 40;

	// phase codes as reported on the result word
	localparam logic [2:0] PH_RED         = 3'd0;
	localparam logic [2:0] PH_RED_YELLOW  = 3'd1;
	localparam logic [2:0] PH_GREEN       = 3'd2;
	localparam logic [2:0] PH_GREEN_BLINK = 3'd3;
	localparam logic [2:0] PH_YELLOW      = 3'd4;
	localparam logic [2:0] PH_NIGHT       = 3'd5;

	// input word kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_PED   = 2'd1;
	localparam logic [1:0] REQ_NIGHT = 2'd2;

	// register indexes
	localparam logic [2:0] REG_RED_TIME           = 3'd0;
	localparam logic [2:0] REG_RED_YELLOW_TIME    = 3'd1;
	localparam logic [2:0] REG_GREEN_TIME         = 3'd2;
	localparam logic [2:0] REG_GREEN_BLINK_TIME   = 3'd3;
	localparam logic [2:0] REG_YELLOW_TIME        = 3'd4;
	localparam logic [2:0] REG_PED_MIN_RED_TIME   = 3'd5;
	localparam logic [2:0] REG_GREEN_BLINK_PERIOD = 3'd6;
	localparam logic [2:0] REG_NIGHT_BLINK_PERIOD = 3'd7;

	localparam logic [15:0] RST_RED_TIME           = 16'd10000;
	localparam logic [15:0] RST_RED_YELLOW_TIME    = 16'd2000;
	localparam logic [15:0] RST_GREEN_TIME         = 16'd10000;
	localparam logic [15:0] RST_GREEN_BLINK_TIME   = 16'd3000;
	localparam logic [15:0] RST_YELLOW_TIME        = 16'd3000;
	localparam logic [15:0] RST_PED_MIN_RED_TIME   = 16'd3000;
	localparam logic [15:0] RST_GREEN_BLINK_PERIOD = 16'd500;
	localparam logic [15:0] RST_NIGHT_BLINK_PERIOD = 16'd500;

	typedef struct packed {
		logic [15:0] red_time;
		logic [15:0] red_yellow_time;
		logic [15:0] green_time;
		logic [15:0] green_blink_time;
		logic [15:0] yellow_time;
		logic [15:0] ped_min_red_time;
		logic [15:0] green_blink_period;
		logic [15:0] night_blink_period;
	} cfg_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       blink_lit;
		logic       request_waiting;
	} ctrl_t;

	typedef struct packed {
		logic       red_lamp;
		logic       yellow_lamp;
		logic       green_lamp;
		logic [2:0] phase;
		logic       ped_pending;
	} status_t;

endpackage

/* rtl/tlpc_cfg_regs.sv */
module tlpc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [tlpc_pkg::CFG_IDX_WIDTH-1:0]   wr_index,
	input  logic [tlpc_pkg::REG_WIDTH-1:0]       wr_data,
	output tlpc_pkg::cfg_t                       cfg
);

	tlpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_time           <= tlpc_pkg::RST_RED_TIME;
			cfg_q.red_yellow_time    <= tlpc_pkg::RST_RED_YELLOW_TIME;
			cfg_q.green_time         <= tlpc_pkg::RST_GREEN_TIME;
			cfg_q.green_blink_time   <= tlpc_pkg::RST_GREEN_BLINK_TIME;
			cfg_q.yellow_time        <= tlpc_pkg::RST_YELLOW_TIME;
			cfg_q.ped_min_red_time   <= tlpc_pkg::RST_PED_MIN_RED_TIME;
			cfg_q.green_blink_period <= tlpc_pkg::RST_GREEN_BLINK_PERIOD;
			cfg_q.night_blink_period <= tlpc_pkg::RST_NIGHT_BLINK_PERIOD;
		end else if (wr_en) begin
			case (wr_index)
				tlpc_pkg::REG_RED_TIME:           cfg_q.red_time           <= wr_data;
				tlpc_pkg::REG_RED_YELLOW_TIME:    cfg_q.red_yellow_time    <= wr_data;
				tlpc_pkg::REG_GREEN_TIME:         cfg_q.green_time         <= wr_data;
				tlpc_pkg::REG_GREEN_BLINK_TIME:   cfg_q.green_blink_time   <= wr_data;
				tlpc_pkg::REG_YELLOW_TIME:        cfg_q.yellow_time        <= wr_data;
				tlpc_pkg::REG_PED_MIN_RED_TIME:   cfg_q.ped_min_red_time   <= wr_data;
				tlpc_pkg::REG_GREEN_BLINK_PERIOD: cfg_q.green_blink_period <= wr_data;
				tlpc_pkg::REG_NIGHT_BLINK_PERIOD: cfg_q.night_blink_period <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/tlpc_step.sv */
module tlpc_step #(
	parameter int COUNT_WIDTH = tlpc_pkg::COUNT_WIDTH_DEF
) (
	input  tlpc_pkg::cfg_t          cfg,
	input  logic [1:0]              req_type,
	input  logic                    night_on,
	input  tlpc_pkg::ctrl_t         cur,
	input  logic [COUNT_WIDTH-1:0]  cur_phase_ticks,
	input  logic [COUNT_WIDTH-1:0]  cur_blink_ticks,
	output tlpc_pkg::ctrl_t         nxt,
	output logic [COUNT_WIDTH-1:0]  nxt_phase_ticks,
	output logic [COUNT_WIDTH-1:0]  nxt_blink_ticks,
	output tlpc_pkg::status_t       status
);

	logic [COUNT_WIDTH-1:0] pt_inc;
	logic [COUNT_WIDTH-1:0] bt_inc;
	logic [COUNT_WIDTH-1:0] duration;
	logic [COUNT_WIDTH-1:0] blink_period;
	logic [COUNT_WIDTH-1:0] ped_min;
	logic [2:0]             next_phase;

	// saturating counters
	assign pt_inc = (&cur_phase_ticks) ? cur_phase_ticks : cur_phase_ticks + 1'b1;
	assign bt_inc = (&cur_blink_ticks) ? cur_blink_ticks : cur_blink_ticks + 1'b1;
	assign ped_min = COUNT_WIDTH'(cfg.ped_min_red_time);
	assign blink_period = (cur.phase == tlpc_pkg::PH_GREEN_BLINK) ?
		COUNT_WIDTH'(cfg.green_blink_period) : COUNT_WIDTH'(cfg.night_blink_period);

	always_comb begin
		case (cur.phase)
			tlpc_pkg::PH_RED: begin
				duration   = COUNT_WIDTH'(cfg.red_time);
				next_phase = tlpc_pkg::PH_RED_YELLOW;
			end
			tlpc_pkg::PH_RED_YELLOW: begin
				duration   = COUNT_WIDTH'(cfg.red_yellow_time);
				next_phase = tlpc_pkg::PH_GREEN;
			end
			tlpc_pkg::PH_GREEN: begin
				duration   = COUNT_WIDTH'(cfg.green_time);
				next_phase = tlpc_pkg::PH_GREEN_BLINK;
			end
			tlpc_pkg::PH_GREEN_BLINK: begin
				duration   = COUNT_WIDTH'(cfg.green_blink_time);
				next_phase = tlpc_pkg::PH_YELLOW;
			end
			tlpc_pkg::PH_YELLOW: begin
				duration   = COUNT_WIDTH'(cfg.yellow_time);
				next_phase = tlpc_pkg::PH_RED;
			end
			default: begin
				duration   = COUNT_WIDTH'(cfg.red_time);
				next_phase = tlpc_pkg::PH_RED;
			end
		endcase
	end

	always_comb begin
		nxt             = cur;
		nxt_phase_ticks = cur_phase_ticks;
		nxt_blink_ticks = cur_blink_ticks;
		case (req_type)
			tlpc_pkg::REQ_TICK: begin
				nxt_phase_ticks = pt_inc;
				nxt_blink_ticks = bt_inc;
				if (cur.phase inside {tlpc_pkg::PH_GREEN_BLINK, tlpc_pkg::PH_NIGHT}) begin
					if (bt_inc >= blink_period) begin
						nxt_blink_ticks = '0;
						nxt.blink_lit   = ~cur.blink_lit;
					end
				end
				if (cur.phase != tlpc_pkg::PH_NIGHT) begin
					// pedestrian cut of red has priority over the normal timeout
					if (cur.request_waiting && cur.phase == tlpc_pkg::PH_RED &&
					    pt_inc >= ped_min) begin
						nxt.request_waiting = 1'b0;
						nxt.phase           = tlpc_pkg::PH_RED_YELLOW;
						nxt.blink_lit       = 1'b1;
						nxt_phase_ticks     = '0;
						nxt_blink_ticks     = '0;
					end else if (pt_inc >= duration) begin
						if (cur.phase == tlpc_pkg::PH_GREEN)
							nxt.request_waiting = 1'b0;
						nxt.phase       = next_phase;
						nxt.blink_lit   = 1'b1;
						nxt_phase_ticks = '0;
						nxt_blink_ticks = '0;
					end
				end
			end
			tlpc_pkg::REQ_PED: begin
				if (cur.phase != tlpc_pkg::PH_NIGHT)
					nxt.request_waiting = 1'b1;
			end
			tlpc_pkg::REQ_NIGHT: begin
				if (night_on) begin
					nxt.request_waiting = 1'b0;
					nxt.phase           = tlpc_pkg::PH_NIGHT;
				end else begin
					nxt.phase = tlpc_pkg::PH_RED;
				end
				nxt.blink_lit   = 1'b1;
				nxt_phase_ticks = '0;
				nxt_blink_ticks = '0;
			end
			default: ;
		endcase
	end

	// lamps follow the state after the word
	always_comb begin
		status.red_lamp    = 1'b0;
		status.yellow_lamp = 1'b0;
		status.green_lamp  = 1'b0;
		status.phase       = nxt.phase;
		status.ped_pending = nxt.request_waiting;
		case (nxt.phase)
			tlpc_pkg::PH_RED:         status.red_lamp = 1'b1;
			tlpc_pkg::PH_RED_YELLOW: begin
				status.red_lamp    = 1'b1;
				status.yellow_lamp = 1'b1;
			end
			tlpc_pkg::PH_GREEN:       status.green_lamp  = 1'b1;
			tlpc_pkg::PH_GREEN_BLINK: status.green_lamp  = nxt.blink_lit;
			tlpc_pkg::PH_YELLOW:      status.yellow_lamp = 1'b1;
			default:                  status.yellow_lamp = nxt.blink_lit;
		endcase
	end

endmodule

/* rtl/traffic_light_phase_controller_core.sv */
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser req_type, tdata night_on
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata lamps, phase, time, pending
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one word per cycle while m_axis_tready stays high; each word is registered at the
// input, then a single pass of compare and counter logic updates the phase state and
// fills the result register, from which the result is presented on m_axis
// reset puts the lights in red with counters at zero and registers at their defaults
// m_axis_tready low holds the result; one more word waits in the input register,
// after which s_axis_tready drops; cfg_ready is always high
module traffic_light_phase_controller_core #(
	parameter int COUNT_WIDTH = tlpc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [0] night_on, [7:1] zero
	input  logic [tlpc_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
	// [1:0] req_type
	input  logic [tlpc_pkg::IN_TUSER_WIDTH-1:0]    s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [0] red_lamp, [1] yellow_lamp, [2] green_lamp, [5:3] phase,
	// [37:6] time_in_phase, [38] ped_pending, [39] zero
	output logic [tlpc_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tlpc_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [tlpc_pkg::REG_WIDTH-1:0]         cfg_data
);

	tlpc_pkg::cfg_t    cfg;
	tlpc_pkg::ctrl_t   ctrl_q;
	tlpc_pkg::ctrl_t   ctrl_nxt;
	tlpc_pkg::status_t status;

	logic                   valid_s1;
	logic [1:0]             req_type_s1;
	logic                   night_on_s1;
	logic [COUNT_WIDTH-1:0] phase_ticks_q;
	logic [COUNT_WIDTH-1:0] blink_ticks_q;
	logic [COUNT_WIDTH-1:0] phase_ticks_nxt;
	logic [COUNT_WIDTH-1:0] blink_ticks_nxt;
	logic                   out_valid_q;
	logic [tlpc_pkg::OUT_TDATA_WIDTH-1:0] out_data_q;
	logic                   s_accept;
	logic                   advance;

	assign cfg_ready = 1'b1;

	tlpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_type_s1 <= s_axis_tuser[1:0];
			night_on_s1 <= s_axis_tdata[0];
		end
	end

	tlpc_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.cfg             (cfg),
		.req_type        (req_type_s1),
		.night_on        (night_on_s1),
		.cur             (ctrl_q),
		.cur_phase_ticks (phase_ticks_q),
		.cur_blink_ticks (blink_ticks_q),
		.nxt             (ctrl_nxt),
		.nxt_phase_ticks (phase_ticks_nxt),
		.nxt_blink_ticks (blink_ticks_nxt),
		.status          (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.phase           <= tlpc_pkg::PH_RED;
			ctrl_q.blink_lit       <= 1'b1;
			ctrl_q.request_waiting <= 1'b0;
			phase_ticks_q          <= '0;
			blink_ticks_q          <= '0;
		end else if (advance) begin
			ctrl_q        <= ctrl_nxt;
			phase_ticks_q <= phase_ticks_nxt;
			blink_ticks_q <= blink_ticks_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {1'b0, status.ped_pending,
				tlpc_pkg::TIME_WIDTH'(phase_ticks_nxt), status.phase,
				status.green_lamp, status.yellow_lamp, status.red_lamp};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// no pending request survives into night
	a_no_ped_at_night: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_q.phase == tlpc_pkg::PH_NIGHT && ctrl_q.request_waiting))
		else $error("pedestrian request pending in night phase");

	// input side stalls only when both stages are full and the output is held
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	// an accepted word sits in the input register on the next cycle
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> valid_s1)
		else $error("accepted word lost at input register");

	// red and green are never lit together on a delivered word
	a_lamp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
		else $error("red and green lamps lit together");

endmodule
